// ===== rtl/core/shrs_pkg.sv =====
package shrs_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned DelayW = 16;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DelayW-1:0] MinDelayMs   = 16'd50;
  localparam logic [DutyW-1:0]  DutyCap      = 7'd98;
  localparam logic [DelayW-1:0] ResetDelayMs = 16'd800;
  localparam logic [DutyW-1:0]  ResetDuty    = 7'd5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIRECTION   = 3'd0,
    REG_START_DELAY = 3'd1,
    REG_TARGET      = 3'd2,
    REG_INTERVAL    = 3'd3,
    REG_DUTY_DUAL   = 3'd4,
    REG_DUTY_SINGLE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic              direction;
    logic [DelayW-1:0] start_delay_ms;
    logic [DelayW-1:0] target_delay_ms;
    logic [DelayW-1:0] ramp_interval;
    logic [DutyW-1:0]  duty_dual_phase;
    logic [DutyW-1:0]  duty_single_phase;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        phase_index;
    logic [CountW-1:0] steps_left;
    logic [DelayW-1:0] current_delay;
    logic [DelayW-1:0] ramp_count;
    logic              busy;
    logic [3:0]        gate_levels;
    logic [DutyW-1:0]  duty_held;
    logic [DelayW-1:0] move_target;
    logic [DelayW-1:0] move_interval;
  } core_t;

  // gate bits: bit0 a+, bit1 a-, bit2 b+, bit3 b-
  function automatic logic [3:0] beat_gates(input logic [2:0] idx);
    logic [3:0] g;
    case (idx)
      3'd0: g = 4'h1;
      3'd1: g = 4'h5;
      3'd2: g = 4'h4;
      3'd3: g = 4'h6;
      3'd4: g = 4'h2;
      3'd5: g = 4'hA;
      3'd6: g = 4'h8;
      3'd7: g = 4'h9;
      default: g = 4'h0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/shrs_if.sv =====
interface shrs_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] step_count;

  modport source (output valid, output operation, output step_count, input ready);
  modport sink   (input valid, input operation, input step_count, output ready);
endinterface

interface shrs_res_if;
  logic       valid;
  logic       ready;
  logic       gate_a_pos;
  logic       gate_a_neg;
  logic       gate_b_pos;
  logic       gate_b_neg;
  logic [6:0] duty_percent;
  logic       moving;
  logic       beat_taken;
  logic [2:0] beat_index;

  modport source (output valid, output gate_a_pos, output gate_a_neg, output gate_b_pos,
                  output gate_b_neg, output duty_percent, output moving,
                  output beat_taken, output beat_index, input ready);
  modport sink   (input valid, input gate_a_pos, input gate_a_neg, input gate_b_pos,
                  input gate_b_neg, input duty_percent, input moving,
                  input beat_taken, input beat_index, output ready);
endinterface

// ===== rtl/core/shrs_step_logic.sv =====
module shrs_step_logic #(
  parameter int unsigned MAX_DELAY_MS = 5000,
  parameter int unsigned WaitW        = 13
) (
  input  logic [1:0]         op_i,
  input  logic [31:0]        step_count_i,
  input  shrs_pkg::cfg_t     cfg_i,
  input  shrs_pkg::core_t    cur_i,
  input  logic [WaitW-1:0]   wait_i,
  output shrs_pkg::core_t    nxt_o,
  output logic [WaitW-1:0]   wait_o,
  output logic               beat_o
);
  import shrs_pkg::*;

  localparam logic [DelayW-1:0] MaxDelay = DelayW'(MAX_DELAY_MS);
  localparam logic [WaitW-1:0]  MaxWait  = WaitW'(MAX_DELAY_MS);

  logic [DelayW-1:0] tgt_raised;
  logic [DelayW-1:0] start_raised;
  core_t             base;
  logic [WaitW-1:0]  wait_dec;
  logic              do_emit;
  logic [DutyW-1:0]  duty_sel;
  logic [DelayW:0]   ramp_inc;

  always_comb begin
    tgt_raised   = (cfg_i.target_delay_ms < MinDelayMs) ? MinDelayMs : cfg_i.target_delay_ms;
    start_raised = (cfg_i.start_delay_ms < MinDelayMs) ? MinDelayMs : cfg_i.start_delay_ms;
    if (start_raised < tgt_raised) begin
      start_raised = tgt_raised;
    end
    wait_dec = (wait_i != '0) ? wait_i - 1'b1 : wait_i;

    base    = cur_i;
    wait_o  = wait_i;
    do_emit = 1'b0;

    case (op_i)
      OP_START: begin
        base.move_target   = tgt_raised;
        base.move_interval = cfg_i.ramp_interval;
        base.current_delay = start_raised;
        base.ramp_count    = '0;
        base.steps_left    = '0;
        base.busy          = 1'b0;
        wait_o             = '0;
        if (step_count_i != '0) begin
          do_emit         = 1'b1;
          base.steps_left = step_count_i - 1'b1;
          base.busy       = 1'b1;
        end
      end
      OP_STOP: begin
        base.gate_levels = '0;
        base.busy        = 1'b0;
        base.steps_left  = '0;
        base.ramp_count  = '0;
        wait_o           = '0;
      end
      OP_TICK: begin
        if (cur_i.busy) begin
          wait_o = wait_dec;
          if (wait_dec == '0) begin
            if (cur_i.steps_left != '0) begin
              do_emit         = 1'b1;
              base.steps_left = cur_i.steps_left - 1'b1;
            end else begin
              base.busy = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // one beat out of the table, then the ramp bookkeeping
    nxt_o    = base;
    duty_sel = base.phase_index[0] ? cfg_i.duty_dual_phase : cfg_i.duty_single_phase;
    ramp_inc = {1'b0, base.ramp_count} + 1'b1;
    if (do_emit) begin
      nxt_o.gate_levels = beat_gates(base.phase_index);
      nxt_o.duty_held   = (duty_sel > DutyCap) ? DutyCap : duty_sel;
      nxt_o.phase_index = cfg_i.direction ? base.phase_index - 1'b1
                                          : base.phase_index + 1'b1;
      wait_o = (base.current_delay > MaxDelay) ? MaxWait
                                               : base.current_delay[WaitW-1:0];
      if (base.current_delay > base.move_target && base.ramp_count == '0) begin
        nxt_o.current_delay = base.current_delay - 1'b1;
      end
      nxt_o.ramp_count = (ramp_inc >= {1'b0, base.move_interval}) ? '0
                                                                    : ramp_inc[DelayW-1:0];
    end
    beat_o = do_emit;
  end

endmodule

// ===== rtl/core/stepper_half_step_ramp_sequencer_core.sv =====
// half-step stepper sequencer with a linear delay ramp
//
// cmd_i carries one command beat: operation (tick, start, stop) and a step
// count used by start. res_o returns exactly one status beat per command:
// the four gate levels, the selected duty, the moving flag, whether this
// command emitted a table beat, and the table index of the next beat.
// configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i, one register
// per cycle, no read-back; write only while the block is idle.
//
// latency: the status beat is valid the cycle after its command is taken.
// throughput: one command per cycle, set by the single result register;
// cmd_i.ready drops only while a result waits and res_o.ready is low, so
// a stalled receiver holds the result steady and back-pressures cmd_i.
//
// reset: all gates low, duty 5, delay 800, phase 0, not moving, registers
// at their documented defaults; no clearing pass, ready straight away.
module stepper_half_step_ramp_sequencer_core #(
  parameter int unsigned MAX_DELAY_MS = 5000
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  shrs_cmd_if.sink                     cmd_i,
  shrs_res_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [shrs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [shrs_pkg::DelayW-1:0]  cfg_data_i
);
  import shrs_pkg::*;

  // wait counter only needs to hold the saturated delay
  localparam int unsigned WaitW = $clog2(MAX_DELAY_MS + 1);

  cfg_t             cfg_q;
  core_t            core_q, core_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic             beat_d;
  logic             res_valid_q;
  logic             beat_q;
  logic             cmd_take;

  // result register frees up when empty or being drained this cycle
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction         <= 1'b0;
      cfg_q.start_delay_ms    <= ResetDelayMs;
      cfg_q.target_delay_ms   <= ResetDelayMs;
      cfg_q.ramp_interval     <= 16'd1;
      cfg_q.duty_dual_phase   <= 7'd15;
      cfg_q.duty_single_phase <= 7'd21;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION:   cfg_q.direction         <= cfg_data_i[0];
        REG_START_DELAY: cfg_q.start_delay_ms    <= cfg_data_i;
        REG_TARGET:      cfg_q.target_delay_ms   <= cfg_data_i;
        REG_INTERVAL:    cfg_q.ramp_interval     <= cfg_data_i;
        REG_DUTY_DUAL:   cfg_q.duty_dual_phase   <= cfg_data_i[DutyW-1:0];
        REG_DUTY_SINGLE: cfg_q.duty_single_phase <= cfg_data_i[DutyW-1:0];
        default: begin
        end
      endcase
    end
  end

  // all per-command work: start, stop, tick, table beat and ramp
  shrs_step_logic #(
    .MAX_DELAY_MS(MAX_DELAY_MS),
    .WaitW       (WaitW)
  ) u_step (
    .op_i        (cmd_i.operation),
    .step_count_i(cmd_i.step_count),
    .cfg_i       (cfg_q),
    .cur_i       (core_q),
    .wait_i      (wait_q),
    .nxt_o       (core_d),
    .wait_o      (wait_d),
    .beat_o      (beat_d)
  );

  // sequencer state, updated once per accepted command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q.phase_index   <= '0;
      core_q.steps_left    <= '0;
      core_q.current_delay <= ResetDelayMs;
      core_q.ramp_count    <= '0;
      core_q.busy          <= 1'b0;
      core_q.gate_levels   <= '0;
      core_q.duty_held     <= ResetDuty;
      core_q.move_target   <= ResetDelayMs;
      core_q.move_interval <= 16'd1;
      wait_q               <= '0;
      beat_q               <= 1'b0;
    end else if (cmd_take) begin
      core_q <= core_d;
      wait_q <= wait_d;
      beat_q <= beat_d;
    end
  end

  // result valid flag; the payload is the state just written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_take) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.gate_a_pos   = core_q.gate_levels[0];
  assign res_o.gate_a_neg   = core_q.gate_levels[1];
  assign res_o.gate_b_pos   = core_q.gate_levels[2];
  assign res_o.gate_b_neg   = core_q.gate_levels[3];
  assign res_o.duty_percent = core_q.duty_held;
  assign res_o.moving       = core_q.busy;
  assign res_o.beat_taken   = beat_q;
  assign res_o.beat_index   = core_q.phase_index;

`ifndef NO_ASSERTIONS
  // a fresh beat always belongs to a running move
  a_beat_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> core_q.busy)
    else $error("beat reported while not moving");

  // stop leaves all gates low and the move aborted
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_take && cmd_i.operation == OP_STOP)
      |=> (core_q.gate_levels == '0 && !core_q.busy && wait_q == '0))
    else $error("stop did not clear the move");

  // loaded wait never exceeds the saturation limit
  a_wait_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wait_q) <= MAX_DELAY_MS)
    else $error("wait counter above maximum delay");

  // an empty result register never back-pressures commands
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> cmd_i.ready)
    else $error("command stalled with empty result register");

  // the working delay never falls below the latched target
  a_delay_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_q.busy |-> (core_q.current_delay >= core_q.move_target))
    else $error("delay ramped below target");
`endif

endmodule

// ===== tb/shrs_status_checker.sv =====
module shrs_status_checker #(
  parameter int unsigned MaxDelayMs = 5000
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  shrs_cmd_if                          cmd_i,
  shrs_res_if                          res_i,
  input  logic                         cfg_we_i,
  input  logic [shrs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [shrs_pkg::DelayW-1:0]  cfg_data_i,
  output int unsigned                  mismatch_cnt_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import shrs_pkg::*;

  localparam logic [DelayW-1:0] ResetInterval   = 16'd1;
  localparam logic [DutyW-1:0]  ResetDutyDual   = 7'd15;
  localparam logic [DutyW-1:0]  ResetDutySingle = 7'd21;

  // half-step table, entry 0 rightmost; bit0 a+, bit1 a-, bit2 b+, bit3 b-
  localparam logic [7:0][3:0] HalfStepGates =
    {4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1};

  typedef struct packed {
    logic [3:0]       gates;
    logic [DutyW-1:0] duty;
    logic             moving;
    logic             beat_taken;
    logic [2:0]       beat_index;
  } status_t;

  cfg_t              regs;
  core_t             seq;
  logic [DelayW-1:0] wait_ms;
  status_t           expected_status_q[$];
  int unsigned       mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  // next table beat: gates, duty, phase step, wait reload and ramp
  function automatic void fire_beat();
    logic [DutyW-1:0] duty_sel;
    duty_sel = seq.phase_index[0] ? regs.duty_dual_phase : regs.duty_single_phase;
    seq.duty_held   = (duty_sel > DutyCap) ? DutyCap : duty_sel;
    seq.gate_levels = HalfStepGates[seq.phase_index];
    seq.phase_index = regs.direction ? seq.phase_index - 3'd1 : seq.phase_index + 3'd1;
    wait_ms = (seq.current_delay > MaxDelayMs) ? DelayW'(MaxDelayMs) : seq.current_delay;
    if (seq.current_delay > seq.move_target && seq.ramp_count == '0) begin
      seq.current_delay = seq.current_delay - 1'b1;
    end
    if ({1'b0, seq.ramp_count} + 17'd1 >= {1'b0, seq.move_interval}) begin
      seq.ramp_count = '0;
    end else begin
      seq.ramp_count = seq.ramp_count + 1'b1;
    end
  endfunction

  function automatic status_t apply_command(input op_e op, input logic [CountW-1:0] cnt);
    status_t           st;
    logic [DelayW-1:0] tgt;
    logic [DelayW-1:0] first_delay;
    st.beat_taken = 1'b0;
    case (op)
      OP_START: begin
        tgt = (regs.target_delay_ms < MinDelayMs) ? MinDelayMs : regs.target_delay_ms;
        first_delay = (regs.start_delay_ms < MinDelayMs) ? MinDelayMs : regs.start_delay_ms;
        if (first_delay < tgt) begin
          first_delay = tgt;
        end
        seq.move_target   = tgt;
        seq.move_interval = regs.ramp_interval;
        seq.current_delay = first_delay;
        seq.ramp_count    = '0;
        seq.steps_left    = '0;
        seq.busy          = 1'b0;
        wait_ms           = '0;
        if (cnt != '0) begin
          fire_beat();
          st.beat_taken  = 1'b1;
          seq.steps_left = cnt - 1'b1;
          seq.busy       = 1'b1;
        end
      end
      OP_STOP: begin
        seq.gate_levels = '0;
        seq.busy        = 1'b0;
        seq.steps_left  = '0;
        seq.ramp_count  = '0;
        wait_ms         = '0;
      end
      OP_TICK: begin
        if (seq.busy) begin
          if (wait_ms != '0) begin
            wait_ms = wait_ms - 1'b1;
          end
          if (wait_ms == '0) begin
            if (seq.steps_left != '0) begin
              fire_beat();
              st.beat_taken  = 1'b1;
              seq.steps_left = seq.steps_left - 1'b1;
            end else begin
              seq.busy = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    st.gates      = seq.gate_levels;
    st.duty       = seq.duty_held;
    st.moving     = seq.busy;
    st.beat_index = seq.phase_index;
    return st;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    status_t seen;
    status_t want;
    if (!rst_ni) begin
      regs.direction         = 1'b0;
      regs.start_delay_ms    = ResetDelayMs;
      regs.target_delay_ms   = ResetDelayMs;
      regs.ramp_interval     = ResetInterval;
      regs.duty_dual_phase   = ResetDutyDual;
      regs.duty_single_phase = ResetDutySingle;
      seq.phase_index        = '0;
      seq.steps_left         = '0;
      seq.current_delay      = ResetDelayMs;
      seq.ramp_count         = '0;
      seq.busy               = 1'b0;
      seq.gate_levels        = '0;
      seq.duty_held          = ResetDuty;
      seq.move_target        = ResetDelayMs;
      seq.move_interval      = ResetInterval;
      wait_ms                = '0;
      expected_status_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_DIRECTION:   regs.direction         = cfg_data_i[0];
          REG_START_DELAY: regs.start_delay_ms    = cfg_data_i;
          REG_TARGET:      regs.target_delay_ms   = cfg_data_i;
          REG_INTERVAL:    regs.ramp_interval     = cfg_data_i;
          REG_DUTY_DUAL:   regs.duty_dual_phase   = cfg_data_i[DutyW-1:0];
          REG_DUTY_SINGLE: regs.duty_single_phase = cfg_data_i[DutyW-1:0];
          default: ;
        endcase
      end
      // status beat leaving the block, matched against the oldest prediction
      if (res_i.valid && res_i.ready) begin
        seen.gates      = {res_i.gate_b_neg, res_i.gate_b_pos, res_i.gate_a_neg, res_i.gate_a_pos};
        seen.duty       = res_i.duty_percent;
        seen.moving     = res_i.moving;
        seen.beat_taken = res_i.beat_taken;
        seen.beat_index = res_i.beat_index;
        if (expected_status_q.size() == 0) begin
          mismatches++;
          $display("%0t: status beat with nothing expected", $time);
        end else begin
          want = expected_status_q.pop_front();
          check_field("gate_a_pos", want.gates[0], seen.gates[0]);
          check_field("gate_a_neg", want.gates[1], seen.gates[1]);
          check_field("gate_b_pos", want.gates[2], seen.gates[2]);
          check_field("gate_b_neg", want.gates[3], seen.gates[3]);
          check_field("duty_percent", want.duty, seen.duty);
          check_field("moving", want.moving, seen.moving);
          check_field("beat_taken", want.beat_taken, seen.beat_taken);
          check_field("beat_index", want.beat_index, seen.beat_index);
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        expected_status_q.push_back(apply_command(op_e'(cmd_i.operation), cmd_i.step_count));
      end
      pending_o <= expected_status_q.size();
    end
  end

endmodule

// ===== tb/tb_stepper_half_step_ramp_sequencer_core.sv =====
module tb_stepper_half_step_ramp_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import shrs_pkg::*;

  // random part runs until this many working beats have gone in
  localparam int unsigned ItemGoal = 1200;
  // receiver hold-off used to back the block up once
  localparam int unsigned LongHoldCycles = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DelayW-1:0]  cfg_data;
  logic               hold_go;
  int unsigned        check_fails;
  int unsigned        check_pending;

  // sender burst state and progress
  int                 burst_left;
  int unsigned        work_items;

  // copy of the delay registers, only for sizing the tick runs
  logic [DelayW-1:0]  plan_start;
  logic [DelayW-1:0]  plan_target;

  shrs_cmd_if cmd_ch ();
  shrs_res_if res_ch ();

  stepper_half_step_ramp_sequencer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  shrs_status_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_ch),
    .res_i          (res_ch),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (check_fails),
    .pending_o      (check_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("stepper_half_step_ramp_sequencer_core test failed");
    $finish;
  end

  // receiver: changes its stall behaviour at random intervals, and once,
  // when asked, holds off for a long stretch so the command side backs up
  initial begin : rx_stall
    int run_len;
    int mode;
    bit held;
    run_len = 0;
    mode    = 0;
    held    = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else begin
        if (run_len == 0) begin
          mode    = $urandom_range(0, 3);
          run_len = $urandom_range(10, 80);
        end
        run_len--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ~res_ch.ready;
        endcase
      end
    end
  end

  // one command beat; opens a new burst after a random gap when the last one is spent
  task automatic send_cmd(input op_e op, input logic [CountW-1:0] cnt, input bit counted);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.step_count <= cnt;
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (counted) work_items++;
  endtask

  // drop valid at the edge of the last accepted beat
  task automatic end_phase();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // wait until every status beat has come back
  task automatic drain();
    do @(posedge clk_i); while (check_pending != 0);
  endtask

  // one register per cycle; caller lowers the write enable afterwards
  task automatic write_reg(input reg_idx_e idx, input logic [DelayW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_START_DELAY) plan_start = val;
    if (idx == REG_TARGET) plan_target = val;
    @(posedge clk_i);
  endtask

  // random register set, then one move of random length with the odd
  // early stop or restart thrown in
  task automatic random_phase(input bit first);
    logic [DelayW-1:0] val;
    logic [DelayW-1:0] tgt_eff;
    logic [DelayW-1:0] eff;
    logic [CountW-1:0] cnt;
    int                beats;
    int                ticks;
    int                cut;
    int                disturb;
    int                k;
    bit                must_stop;

    drain();
    if ($urandom_range(0, 3) != 0) write_reg(REG_DIRECTION, DelayW'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = DelayW'($urandom_range(1, 49));
        2:       val = 16'hFFFF;
        default: val = DelayW'($urandom_range(50, 90));
      endcase
      write_reg(REG_START_DELAY, val);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 15))
        0, 1:    val = '0;
        2, 3:    val = DelayW'($urandom_range(1, 49));
        4:       val = 16'hFFFF;
        5:       val = DelayW'($urandom_range(0, 65535));
        default: val = DelayW'($urandom_range(50, 62));
      endcase
      write_reg(REG_TARGET, val);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0:       val = 16'd1;
        1:       val = 16'hFFFF;
        2:       val = DelayW'($urandom_range(1, 65535));
        default: val = DelayW'($urandom_range(1, 3));
      endcase
      write_reg(REG_INTERVAL, val);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       val = '0;
        1:       val = 16'd98;
        default: val = DelayW'($urandom_range(0, 98));
      endcase
      write_reg(REG_DUTY_DUAL, val);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       val = '0;
        1:       val = 16'd98;
        default: val = DelayW'($urandom_range(0, 98));
      endcase
      write_reg(REG_DUTY_SINGLE, val);
    end
    cfg_we <= 1'b0;

    // effective first delay, as the block will load it
    tgt_eff = (plan_target < MinDelayMs) ? MinDelayMs : plan_target;
    eff     = (plan_start < MinDelayMs) ? MinDelayMs : plan_start;
    if (eff < tgt_eff) eff = tgt_eff;

    case ($urandom_range(0, 11))
      0:          cnt = '0;
      1, 2:       cnt = $urandom();
      3, 4, 5:    cnt = CountW'($urandom_range(5, 14));
      default:    cnt = CountW'($urandom_range(1, 4));
    endcase
    if (first && cnt == '0) cnt = 32'd3;

    must_stop = 1'b0;
    beats     = (cnt > 32'd14) ? 0 : int'(cnt);
    if (eff > 16'd300) begin
      // long delays: a few hundred ticks at most, then abort
      ticks     = (cnt == '0) ? 0 : $urandom_range(2, 250);
      must_stop = (cnt != '0);
    end else if (cnt > 32'd14) begin
      ticks     = $urandom_range(int'(eff), 3 * int'(eff));
      must_stop = 1'b1;
    end else begin
      // enough ticks to run the whole move; the ramp only shortens it
      ticks = int'(eff) * beats;
      // long moves are cut short to keep each phase small
      if (ticks > 400) begin
        ticks     = $urandom_range(100, 400);
        must_stop = 1'b1;
      end
    end

    disturb = (ticks > 0) ? $urandom_range(0, 7) : 7;
    cut     = (ticks > 0) ? $urandom_range(0, ticks - 1) : 0;

    if ($urandom_range(0, 5) == 0) send_cmd(OP_STOP, $urandom(), 1'b1);
    send_cmd(OP_START, cnt, 1'b1);
    if (first) hold_go <= 1'b1;

    for (k = 0; k < ticks; k++) begin
      // beat budget spent: abort whatever is still running
      if (work_items >= ItemGoal) begin
        must_stop = 1'b1;
        break;
      end
      if (k == cut && disturb == 0) begin
        send_cmd(OP_STOP, $urandom(), 1'b1);
        break;
      end
      if (k == cut && disturb == 1) begin
        send_cmd(OP_START, CountW'($urandom_range(1, 3)), 1'b1);
        must_stop = 1'b1;
      end
      send_cmd(OP_TICK, $urandom(), 1'b1);
    end
    // a couple of ticks past the end: move finished or idle status
    repeat ($urandom_range(0, 2)) send_cmd(OP_TICK, $urandom(), 1'b0);
    if (must_stop) send_cmd(OP_STOP, '0, 1'b1);
    end_phase();
  endtask

  // working delay far above the maximum, with small low bits, so a reload
  // that truncates instead of capping would beat within a few ticks
  task automatic saturation_phase();
    int k;
    drain();
    write_reg(REG_START_DELAY, 16'h2005);
    write_reg(REG_TARGET, '0);
    write_reg(REG_INTERVAL, 16'd1);
    cfg_we <= 1'b0;
    send_cmd(OP_START, 32'd2, 1'b0);
    for (k = 0; k < 40; k++) send_cmd(OP_TICK, $urandom(), 1'b0);
    send_cmd(OP_STOP, '0, 1'b0);
    end_phase();
  endtask

  initial begin : stimulus
    int phase_no;

    rst_ni = 1'b0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.operation  <= OP_TICK;
    cmd_ch.step_count <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_DIRECTION;
    cfg_data          <= '0;
    hold_go           <= 1'b0;
    burst_left  = 0;
    work_items  = 0;
    plan_start  = ResetDelayMs;
    plan_target = ResetDelayMs;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: idle status, stop while idle, empty start,
    // single-beat move, abort, full-range count and a restart mid-move
    send_cmd(OP_TICK, '0, 1'b1);
    send_cmd(OP_STOP, '0, 1'b1);
    send_cmd(OP_START, '0, 1'b1);
    send_cmd(OP_START, 32'd1, 1'b1);
    send_cmd(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_STOP, '0, 1'b1);
    send_cmd(OP_START, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_START, 32'h8000_0000, 1'b1);
    send_cmd(OP_STOP, '0, 1'b1);
    end_phase();

    // backward, both delays below the floor, widest interval, duty extremes
    drain();
    write_reg(REG_DIRECTION, 16'd1);
    write_reg(REG_START_DELAY, '0);
    write_reg(REG_TARGET, '0);
    write_reg(REG_INTERVAL, 16'hFFFF);
    write_reg(REG_DUTY_DUAL, 16'd98);
    write_reg(REG_DUTY_SINGLE, '0);
    cfg_we <= 1'b0;
    send_cmd(OP_START, 32'd3, 1'b1);
    send_cmd(OP_TICK, '0, 1'b1);
    send_cmd(OP_START, 32'd1, 1'b1);
    send_cmd(OP_STOP, '0, 1'b1);
    end_phase();

    // forward, delays at the top, zero-count start while moving keeps the gates
    drain();
    write_reg(REG_DIRECTION, '0);
    write_reg(REG_START_DELAY, 16'hFFFF);
    write_reg(REG_TARGET, 16'hFFFF);
    write_reg(REG_INTERVAL, 16'd1);
    write_reg(REG_DUTY_DUAL, '0);
    write_reg(REG_DUTY_SINGLE, 16'd98);
    cfg_we <= 1'b0;
    send_cmd(OP_START, 32'd2, 1'b1);
    send_cmd(OP_TICK, '0, 1'b1);
    send_cmd(OP_START, '0, 1'b1);
    send_cmd(OP_TICK, '0, 1'b1);
    send_cmd(OP_STOP, '0, 1'b1);
    end_phase();

    // random moves; the capped-wait run goes in once near the start
    phase_no = 0;
    while (work_items < ItemGoal) begin
      if (phase_no == 1) saturation_phase();
      else random_phase(phase_no == 0);
      phase_no++;
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (check_fails == 0 && check_pending == 0) begin
      $display("stepper_half_step_ramp_sequencer_core test passed");
    end else begin
      $display("stepper_half_step_ramp_sequencer_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/shrs_pkg.sv
rtl/core/shrs_if.sv
rtl/core/shrs_step_logic.sv
rtl/core/stepper_half_step_ramp_sequencer_core.sv
tb/shrs_status_checker.sv
tb/tb_stepper_half_step_ramp_sequencer_core.sv
